>>> sv/fsae_pkg.sv
// ---------------------------------------------------------------------------
// fsae_pkg
// shared types, sizes and codes of the forth stack alu executor
// ---------------------------------------------------------------------------
package fsae_pkg;

   localparam int DS_DEPTH = 256;
   localparam int DS_AW    = $clog2(DS_DEPTH);
   localparam int DS_CW    = DS_AW + 1;
   localparam int RS_DEPTH = 64;
   localparam int RS_AW    = $clog2(RS_DEPTH);
   localparam int RS_CW    = RS_AW + 1;
   localparam int IP_BITS  = 32;
   localparam int CELL_W   = 64;
   localparam int IT_W     = $clog2(CELL_W);

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_STOP  = 3'd1;
   localparam logic [2:0] ST_STACK = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_UNSUP = 3'd4;

   localparam logic [6:0] OP_STOP    = 7'd0;
   localparam logic [6:0] OP_LIT     = 7'd1;
   localparam logic [6:0] OP_JUMP    = 7'd2;
   localparam logic [6:0] OP_ZBRANCH = 7'd3;
   localparam logic [6:0] OP_SLIT    = 7'd7;
   localparam logic [6:0] OP_TOR     = 7'd8;
   localparam logic [6:0] OP_RFROM   = 7'd9;
   localparam logic [6:0] OP_RFETCH  = 7'd10;
   localparam logic [6:0] OP_PUSH    = 7'd11;
   localparam logic [6:0] OP_DUP     = 7'd13;
   localparam logic [6:0] OP_DROP    = 7'd14;
   localparam logic [6:0] OP_SWAP    = 7'd15;
   localparam logic [6:0] OP_OVER    = 7'd16;
   localparam logic [6:0] OP_NIP     = 7'd17;
   localparam logic [6:0] OP_TUCK    = 7'd18;
   localparam logic [6:0] OP_ROT     = 7'd19;
   localparam logic [6:0] OP_MROT    = 7'd20;
   localparam logic [6:0] OP_2DUP    = 7'd21;
   localparam logic [6:0] OP_2DROP   = 7'd22;
   localparam logic [6:0] OP_2OVER   = 7'd23;
   localparam logic [6:0] OP_2SWAP   = 7'd24;
   localparam logic [6:0] OP_QDUP    = 7'd25;
   localparam logic [6:0] OP_PICK    = 7'd26;
   localparam logic [6:0] OP_ADD     = 7'd27;
   localparam logic [6:0] OP_SUB     = 7'd28;
   localparam logic [6:0] OP_MUL     = 7'd29;
   localparam logic [6:0] OP_DIVQ    = 7'd30;
   localparam logic [6:0] OP_MOD     = 7'd31;
   localparam logic [6:0] OP_DIVREM  = 7'd32;
   localparam logic [6:0] OP_NEG     = 7'd33;
   localparam logic [6:0] OP_ABS     = 7'd34;
   localparam logic [6:0] OP_MIN     = 7'd35;
   localparam logic [6:0] OP_MAX     = 7'd36;
   localparam logic [6:0] OP_INC     = 7'd37;
   localparam logic [6:0] OP_DEC     = 7'd38;
   localparam logic [6:0] OP_SHL1    = 7'd39;
   localparam logic [6:0] OP_SHR1A   = 7'd40;
   localparam logic [6:0] OP_AND     = 7'd41;
   localparam logic [6:0] OP_OR      = 7'd42;
   localparam logic [6:0] OP_XOR     = 7'd43;
   localparam logic [6:0] OP_SHL     = 7'd44;
   localparam logic [6:0] OP_SHR     = 7'd45;
   localparam logic [6:0] OP_NOT     = 7'd46;
   localparam logic [6:0] OP_EQ      = 7'd47;
   localparam logic [6:0] OP_NE      = 7'd48;
   localparam logic [6:0] OP_ZEQ     = 7'd49;
   localparam logic [6:0] OP_ZNE     = 7'd50;
   localparam logic [6:0] OP_ZLT     = 7'd51;
   localparam logic [6:0] OP_ZGT     = 7'd52;
   localparam logic [6:0] OP_ULT     = 7'd53;
   localparam logic [6:0] OP_UGT     = 7'd54;
   localparam logic [6:0] OP_LT      = 7'd55;
   localparam logic [6:0] OP_LE      = 7'd56;
   localparam logic [6:0] OP_GT      = 7'd57;
   localparam logic [6:0] OP_GE      = 7'd58;
   localparam logic [6:0] OP_INRANGE = 7'd59;
   localparam logic [6:0] OP_BYTEREV = 7'd72;

   typedef struct packed {
      logic [6:0]        opcode;
      logic [CELL_W-1:0] operand_a;
      logic [CELL_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [CELL_W-1:0]  top_cell;
      logic [CELL_W-1:0]  second_cell;
      logic [DS_CW-1:0]   data_count;
      logic [RS_CW-1:0]   return_count;
      logic [IP_BITS-1:0] next_ip;
   } rsp_type;

endpackage

>>> sv/forth_stack_alu_executor.sv
// ---------------------------------------------------------------------------
// forth_stack_alu_executor
// executes one forth primitive per word against a data stack, a return
// stack and an instruction pointer, 64-bit cells
// ---------------------------------------------------------------------------
//  channel | handshake                 | word
//  --------+---------------------------+---------------------------------
//  req     | req_valid / req_stall     | req_word  (opcode, operand_a/b)
//  rsp     | rsp_valid / rsp_stall     | rsp_word  (status, view of machine)
//
//  a word runs: fetch the top four cells, decode, push each cell, settle
//  the depth, read back the new top pair, present the result, and back in
//  idle take the next word; a faulting word skips the pushes; pick adds a
//  read of the picked cell; * adds shift-add passes of the one shared 65-bit
//  adder, the divisions passes of it plus a state to fix signs
//  reset clears depths, instruction pointer and sequencer; stack memories
//  hold garbage until pushed
//  the result sits in an output register, so the next word is taken while
//  rsp_stall holds the previous one
// ---------------------------------------------------------------------------
module forth_stack_alu_executor (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fsae_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fsae_pkg::rsp_type rsp_word
);
   import fsae_pkg::*;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_PICK  = 4'd2;
   localparam logic [3:0] S_PICKW = 4'd3;
   localparam logic [3:0] S_EXEC  = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_DFIX  = 4'd7;
   localparam logic [3:0] S_WRITE = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   localparam logic [CELL_W-1:0] TOP_BIT = {1'b1, {(CELL_W-1){1'b0}}};
   localparam logic [CELL_W-1:0] ONES    = {CELL_W{1'b1}};

   // stack memories
   logic [CELL_W-1:0] data_mem [DS_DEPTH];
   logic [CELL_W-1:0] ret_mem  [RS_DEPTH];
   logic [CELL_W-1:0] dq_rd_ff, rq_rd_ff;
   logic [DS_AW-1:0]  d_raddr, d_waddr;
   logic [RS_AW-1:0]  r_raddr, r_waddr;
   logic [CELL_W-1:0] d_wdata;
   logic              d_we, r_we;

   // control and machine state
   logic [3:0]         state_ff, state_in;
   logic [2:0]         k_ff, k_in;
   logic [IT_W-1:0]    iter_ff, iter_in;
   logic [DS_CW-1:0]   dd_ff, dd_in;
   logic [RS_CW-1:0]   rd_ff, rd_in;
   logic [IP_BITS-1:0] ip_ff, ip_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // work registers
   logic [6:0]        op_ff, op_in;
   logic [CELL_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [CELL_W-1:0] v_ff [4];
   logic [CELL_W-1:0] v_in [4];
   logic [CELL_W-1:0] pick_ff, pick_in, rtop_ff, rtop_in;
   logic [CELL_W-1:0] res_ff [6];
   logic [CELL_W-1:0] res_in [6];
   logic [2:0]        nout_ff, nout_in;
   logic [DS_CW-1:0]  base_ff, base_in;
   logic [2:0]        stat_ff, stat_in;
   logic [CELL_W-1:0] acc_ff, acc_in, sh_ff, sh_in, opd_ff, opd_in;
   logic [CELL_W-1:0] top_ff, top_in, sec_ff, sec_in;
   rsp_type           rsp_ff, rsp_in;

   // shared adder
   logic [CELL_W-1:0] add_x, add_y;
   logic              add_sub;
   logic [CELL_W:0]   add_sum;
   logic [CELL_W-1:0] rem_sh;

   // decode
   logic [2:0]         nin_c, nout_c, stat_c;
   logic [CELL_W-1:0]  r_c [6];
   logic [IP_BITS-1:0] ip_c;
   logic               push_c, pop_c, range_bad, div_bad, is_mul, is_div;
   logic [DS_CW+1:0]   grow_c;
   logic [DS_CW-1:0]   dm2;
   logic [CELL_W-1:0]  abs1, abs0;

   assign rem_sh  = {acc_ff[CELL_W-2:0], sh_ff[CELL_W-1]};
   assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {CELL_W{add_sub}}}
                    + {{CELL_W{1'b0}}, add_sub};
   assign dm2     = dd_ff - DS_CW'(2);
   assign abs1    = v_ff[1][CELL_W-1] ? CELL_W'(0) - v_ff[1] : v_ff[1];
   assign abs0    = v_ff[0][CELL_W-1] ? CELL_W'(0) - v_ff[0] : v_ff[0];

   always_comb begin
      add_x   = acc_ff;
      add_y   = opd_ff;
      add_sub = 1'b0;
      if (state_ff == S_DIV) begin
         add_x   = rem_sh;
         add_sub = 1'b1;
      end
   end

   // primitive decode over the fetched cells
   always_comb begin
      nin_c     = 3'd0;
      nout_c    = 3'd0;
      stat_c    = ST_OK;
      ip_c      = ip_ff + IP_BITS'(1);
      push_c    = 1'b0;
      pop_c     = 1'b0;
      range_bad = 1'b0;
      div_bad   = 1'b0;
      is_mul    = 1'b0;
      is_div    = 1'b0;
      for (int i = 0; i < 6; i++) r_c[i] = '0;
      case (op_ff)
         OP_STOP:    stat_c = ST_STOP;
         OP_LIT, OP_PUSH: begin r_c[0] = a_ff; nout_c = 3'd1; end
         OP_JUMP:    ip_c = a_ff[IP_BITS-1:0];
         OP_ZBRANCH: begin
            nin_c = 3'd1;
            if (v_ff[0] == '0) ip_c = a_ff[IP_BITS-1:0];
         end
         OP_SLIT:    begin r_c[0] = a_ff; r_c[1] = b_ff; nout_c = 3'd2; end
         OP_TOR: begin
            nin_c = 3'd1; push_c = 1'b1;
            range_bad = (rd_ff >= RS_CW'(RS_DEPTH));
         end
         OP_RFROM, OP_RFETCH: begin
            nout_c = 3'd1; r_c[0] = rtop_ff;
            range_bad = (rd_ff == '0) || (rd_ff > RS_CW'(RS_DEPTH));
            pop_c = (op_ff == OP_RFROM);
         end
         OP_DUP:   begin nin_c = 3'd1; r_c[0] = v_ff[0]; r_c[1] = v_ff[0]; nout_c = 3'd2; end
         OP_DROP:  nin_c = 3'd1;
         OP_SWAP:  begin nin_c = 3'd2; r_c[0] = v_ff[0]; r_c[1] = v_ff[1]; nout_c = 3'd2; end
         OP_OVER: begin
            nin_c = 3'd2; nout_c = 3'd3;
            r_c[0] = v_ff[1]; r_c[1] = v_ff[0]; r_c[2] = v_ff[1];
         end
         OP_NIP:   begin nin_c = 3'd2; r_c[0] = v_ff[0]; nout_c = 3'd1; end
         OP_TUCK: begin
            nin_c = 3'd2; nout_c = 3'd3;
            r_c[0] = v_ff[0]; r_c[1] = v_ff[1]; r_c[2] = v_ff[0];
         end
         OP_ROT: begin
            nin_c = 3'd3; nout_c = 3'd3;
            r_c[0] = v_ff[1]; r_c[1] = v_ff[0]; r_c[2] = v_ff[2];
         end
         OP_MROT: begin
            nin_c = 3'd3; nout_c = 3'd3;
            r_c[0] = v_ff[0]; r_c[1] = v_ff[2]; r_c[2] = v_ff[1];
         end
         OP_2DUP: begin
            nin_c = 3'd2; nout_c = 3'd4;
            r_c[0] = v_ff[1]; r_c[1] = v_ff[0]; r_c[2] = v_ff[1]; r_c[3] = v_ff[0];
         end
         OP_2DROP: nin_c = 3'd2;
         OP_2OVER: begin
            nin_c = 3'd4; nout_c = 3'd6;
            r_c[0] = v_ff[3]; r_c[1] = v_ff[2]; r_c[2] = v_ff[1];
            r_c[3] = v_ff[0]; r_c[4] = v_ff[3]; r_c[5] = v_ff[2];
         end
         OP_2SWAP: begin
            nin_c = 3'd4; nout_c = 3'd4;
            r_c[0] = v_ff[1]; r_c[1] = v_ff[0]; r_c[2] = v_ff[3]; r_c[3] = v_ff[2];
         end
         OP_QDUP: begin
            nin_c = 3'd1; r_c[0] = v_ff[0]; r_c[1] = v_ff[0];
            nout_c = (v_ff[0] != '0) ? 3'd2 : 3'd1;
         end
         OP_PICK: begin
            nin_c = 3'd1; nout_c = 3'd1; r_c[0] = pick_ff;
            range_bad = (dd_ff < DS_CW'(2)) || (v_ff[0] > CELL_W'(dm2));
         end
         OP_ADD:   begin nin_c = 3'd2; nout_c = 3'd1; r_c[0] = v_ff[1] + v_ff[0]; end
         OP_SUB:   begin nin_c = 3'd2; nout_c = 3'd1; r_c[0] = v_ff[1] - v_ff[0]; end
         OP_MUL:   begin nin_c = 3'd2; nout_c = 3'd1; is_mul = 1'b1; end
         OP_DIVQ, OP_MOD, OP_DIVREM: begin
            nin_c = 3'd2; is_div = 1'b1;
            nout_c = (op_ff == OP_DIVREM) ? 3'd2 : 3'd1;
            div_bad = (v_ff[0] == '0) ||
                      (op_ff != OP_MOD && v_ff[1] == TOP_BIT && v_ff[0] == ONES);
         end
         OP_NEG:    begin nin_c = 3'd1; nout_c = 3'd1; r_c[0] = CELL_W'(0) - v_ff[0]; end
         OP_ABS:    begin nin_c = 3'd1; nout_c = 3'd1; r_c[0] = abs0; end
         OP_MIN: begin
            nin_c = 3'd2; nout_c = 3'd1;
            r_c[0] = ($signed(v_ff[0]) < $signed(v_ff[1])) ? v_ff[0] : v_ff[1];
         end
         OP_MAX: begin
            nin_c = 3'd2; nout_c = 3'd1;
            r_c[0] = ($signed(v_ff[1]) < $signed(v_ff[0])) ? v_ff[0] : v_ff[1];
         end
         OP_INC:   begin nin_c = 3'd1; nout_c = 3'd1; r_c[0] = v_ff[0] + CELL_W'(1); end
         OP_DEC:   begin nin_c = 3'd1; nout_c = 3'd1; r_c[0] = v_ff[0] - CELL_W'(1); end
         OP_SHL1:  begin nin_c = 3'd1; nout_c = 3'd1; r_c[0] = v_ff[0] << 1; end
         OP_SHR1A: begin
            nin_c = 3'd1; nout_c = 3'd1;
            r_c[0] = (v_ff[0] >> 1) | (v_ff[0] & TOP_BIT);
         end
         OP_AND:   begin nin_c = 3'd2; nout_c = 3'd1; r_c[0] = v_ff[1] & v_ff[0]; end
         OP_OR:    begin nin_c = 3'd2; nout_c = 3'd1; r_c[0] = v_ff[1] | v_ff[0]; end
         OP_XOR:   begin nin_c = 3'd2; nout_c = 3'd1; r_c[0] = v_ff[1] ^ v_ff[0]; end
         OP_SHL: begin
            nin_c = 3'd2; nout_c = 3'd1; r_c[0] = v_ff[1] << v_ff[0][5:0];
         end
         OP_SHR: begin
            nin_c = 3'd2; nout_c = 3'd1; r_c[0] = v_ff[1] >> v_ff[0][5:0];
         end
         OP_NOT: begin nin_c = 3'd1; nout_c = 3'd1; r_c[0] = ~v_ff[0]; end
         OP_EQ:  begin nin_c = 3'd2; nout_c = 3'd1; r_c[0] = {CELL_W{v_ff[1] == v_ff[0]}}; end
         OP_NE:  begin nin_c = 3'd2; nout_c = 3'd1; r_c[0] = {CELL_W{v_ff[1] != v_ff[0]}}; end
         OP_ZEQ: begin nin_c = 3'd1; nout_c = 3'd1; r_c[0] = {CELL_W{v_ff[0] == '0}}; end
         OP_ZNE: begin nin_c = 3'd1; nout_c = 3'd1; r_c[0] = {CELL_W{v_ff[0] != '0}}; end
         OP_ZLT: begin nin_c = 3'd1; nout_c = 3'd1; r_c[0] = {CELL_W{v_ff[0][CELL_W-1]}}; end
         OP_ZGT: begin
            nin_c = 3'd1; nout_c = 3'd1;
            r_c[0] = {CELL_W{v_ff[0] != '0 && !v_ff[0][CELL_W-1]}};
         end
         OP_ULT: begin nin_c = 3'd2; nout_c = 3'd1; r_c[0] = {CELL_W{v_ff[1] < v_ff[0]}}; end
         OP_UGT: begin nin_c = 3'd2; nout_c = 3'd1; r_c[0] = {CELL_W{v_ff[1] > v_ff[0]}}; end
         OP_LT: begin
            nin_c = 3'd2; nout_c = 3'd1;
            r_c[0] = {CELL_W{$signed(v_ff[1]) < $signed(v_ff[0])}};
         end
         OP_LE: begin
            nin_c = 3'd2; nout_c = 3'd1;
            r_c[0] = {CELL_W{!($signed(v_ff[0]) < $signed(v_ff[1]))}};
         end
         OP_GT: begin
            nin_c = 3'd2; nout_c = 3'd1;
            r_c[0] = {CELL_W{$signed(v_ff[0]) < $signed(v_ff[1])}};
         end
         OP_GE: begin
            nin_c = 3'd2; nout_c = 3'd1;
            r_c[0] = {CELL_W{!($signed(v_ff[1]) < $signed(v_ff[0]))}};
         end
         OP_INRANGE: begin
            nin_c = 3'd3; nout_c = 3'd1;
            r_c[0] = {CELL_W{(v_ff[2] - v_ff[1]) < (v_ff[0] - v_ff[1])}};
         end
         OP_BYTEREV: begin
            nin_c = 3'd1; nout_c = 3'd1;
            for (int i = 0; i < 8; i++) r_c[0][8*(7-i) +: 8] = v_ff[0][8*i +: 8];
         end
         default: stat_c = ST_UNSUP;
      endcase
      // depth after the word, two bits of headroom
      grow_c = {2'b00, dd_ff} - {{(DS_CW-1){1'b0}}, nin_c} + {{(DS_CW-1){1'b0}}, nout_c};
      if (stat_c == ST_OK) begin
         if (dd_ff < DS_CW'(nin_c) || range_bad) stat_c = ST_STACK;
         else if (div_bad) stat_c = ST_DIV;
         else if (grow_c > (DS_CW+2)'(DS_DEPTH)) stat_c = ST_STACK;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      iter_in      = iter_ff;
      dd_in        = dd_ff;
      rd_in        = rd_ff;
      ip_in        = ip_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      v_in         = v_ff;
      pick_in      = pick_ff;
      rtop_in      = rtop_ff;
      res_in       = res_ff;
      nout_in      = nout_ff;
      base_in      = base_ff;
      stat_in      = stat_ff;
      acc_in       = acc_ff;
      sh_in        = sh_ff;
      opd_in       = opd_ff;
      top_in       = top_ff;
      sec_in       = sec_ff;
      rsp_in       = rsp_ff;
      d_raddr      = DS_AW'(dd_ff - DS_CW'(1) - DS_CW'(k_ff));
      r_raddr      = RS_AW'(rd_ff - RS_CW'(1));
      d_waddr      = DS_AW'(base_ff + DS_CW'(k_ff));
      d_wdata      = res_ff[0];
      d_we         = 1'b0;
      r_waddr      = rd_ff[RS_AW-1:0];
      r_we         = 1'b0;
      for (int i = 0; i < 6; i++) if (k_ff == 3'(i)) d_wdata = res_ff[i];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_word.opcode;
               a_in     = req_word.operand_a;
               b_in     = req_word.operand_b;
               k_in     = '0;
               state_in = S_READ;
            end
         end
         // fetch the top four cells, one read a cycle, each captured in the next cycle
         S_READ: begin
            if (k_ff != '0) begin
               for (int i = 0; i < 4; i++) begin
                  if (k_ff == 3'(i + 1))
                     v_in[i] = (DS_CW'(i) < dd_ff) ? dq_rd_ff : '0;
               end
            end
            if (k_ff == 3'd1) rtop_in = rq_rd_ff;
            if (k_ff == 3'd4) begin
               k_in     = '0;
               state_in = S_EXEC;
               if (op_ff == OP_PICK && dd_ff >= DS_CW'(2) && v_ff[0] <= CELL_W'(dm2))
                  state_in = S_PICK;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         S_PICK: begin
            d_raddr  = DS_AW'(dm2 - v_ff[0][DS_CW-1:0]);
            state_in = S_PICKW;
         end
         S_PICKW: begin
            pick_in  = dq_rd_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            stat_in = stat_c;
            k_in    = '0;
            if (stat_c != ST_OK) begin
               state_in = S_OUT;
            end else begin
               base_in = dd_ff - DS_CW'(nin_c);
               nout_in = nout_c;
               res_in  = r_c;
               ip_in   = ip_c;
               if (push_c) begin
                  r_we  = 1'b1;
                  rd_in = rd_ff + RS_CW'(1);
               end
               if (pop_c) rd_in = rd_ff - RS_CW'(1);
               iter_in = '0;
               acc_in  = '0;
               if (is_mul) begin
                  sh_in    = v_ff[0];
                  opd_in   = v_ff[1];
                  state_in = S_MUL;
               end else if (is_div) begin
                  sh_in    = abs1;
                  opd_in   = abs0;
                  state_in = S_DIV;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         // shift-add multiply, low half only
         S_MUL: begin
            if (sh_ff[0]) acc_in = add_sum[CELL_W-1:0];
            opd_in  = opd_ff << 1;
            sh_in   = sh_ff >> 1;
            iter_in = iter_ff + IT_W'(1);
            if (iter_ff == '1) begin
               res_in[0] = acc_in;
               state_in  = S_WRITE;
            end
         end
         // restoring divide on magnitudes
         S_DIV: begin
            if (add_sum[CELL_W]) begin
               acc_in = add_sum[CELL_W-1:0];
               sh_in  = {sh_ff[CELL_W-2:0], 1'b1};
            end else begin
               acc_in = rem_sh;
               sh_in  = {sh_ff[CELL_W-2:0], 1'b0};
            end
            iter_in = iter_ff + IT_W'(1);
            if (iter_ff == '1) state_in = S_DFIX;
         end
         // signs back: quotient by both, remainder by the dividend
         S_DFIX: begin
            res_in[1] = (v_ff[1][CELL_W-1] ^ v_ff[0][CELL_W-1]) ? CELL_W'(0) - sh_ff : sh_ff;
            res_in[0] = v_ff[1][CELL_W-1] ? CELL_W'(0) - acc_ff : acc_ff;
            if (op_ff == OP_DIVQ) res_in[0] = res_in[1];
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (k_ff < nout_ff) begin
               d_we = 1'b1;
               k_in = k_ff + 3'd1;
            end else begin
               dd_in    = base_ff + DS_CW'(nout_ff);
               k_in     = '0;
               state_in = S_OUT;
            end
         end
         // read back top and second
         S_OUT: begin
            if (k_ff == 3'd1) top_in = (dd_ff >= DS_CW'(1)) ? dq_rd_ff : '0;
            if (k_ff == 3'd2) begin
               sec_in   = (dd_ff >= DS_CW'(2)) ? dq_rd_ff : '0;
               state_in = S_DONE;
            end
            k_in = k_ff + 3'd1;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = stat_ff;
               rsp_in.top_cell     = top_ff;
               rsp_in.second_cell  = sec_ff;
               rsp_in.data_count   = dd_ff;
               rsp_in.return_count = rd_ff;
               rsp_in.next_ip      = ip_ff;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (d_we) data_mem[d_waddr] <= d_wdata;
      dq_rd_ff <= data_mem[d_raddr];
      if (r_we) ret_mem[r_waddr] <= v_ff[0];
      rq_rd_ff <= ret_mem[r_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         iter_ff      <= '0;
         dd_ff        <= '0;
         rd_ff        <= '0;
         ip_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         iter_ff      <= iter_in;
         dd_ff        <= dd_in;
         rd_ff        <= rd_in;
         ip_ff        <= ip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      v_ff    <= v_in;
      pick_ff <= pick_in;
      rtop_ff <= rtop_in;
      res_ff  <= res_in;
      nout_ff <= nout_in;
      base_ff <= base_in;
      stat_ff <= stat_in;
      acc_ff  <= acc_in;
      sh_ff   <= sh_in;
      opd_ff  <= opd_in;
      top_ff  <= top_in;
      sec_ff  <= sec_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // a word taken puts the sequencer to work at once
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sequencer did not leave idle after taking a word");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.data_count <= DS_CW'(DS_DEPTH)
                     && rsp_word.return_count <= RS_CW'(RS_DEPTH)))
      else $error("stack depth beyond capacity");

   // a faulting word leaves the data depth alone
   a_fault_keeps_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && stat_c != ST_OK) |=> $stable(dd_ff))
      else $error("faulting word changed the data depth");

endmodule
